/* rtl/core/rld_pkg.sv */
// shared types and constants for the run-length decoder
`timescale 1ns / 1ps
package rld_pkg;

  localparam int BYTE_W     = 8;
  localparam int ELEM_W     = 64;
  localparam int CNT_W      = 32;
  localparam int TOTAL_W    = 40;
  localparam int HDR_W      = 32;
  localparam int POS_W      = 3;
  localparam int EB_W       = 4;
  localparam int HB_W       = 3;
  localparam int PROD_W     = CNT_W + EB_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_DATA_W = ELEM_W + CNT_W + TOTAL_W;

  localparam logic [EB_W-1:0] MAX_ELEMENT_BYTES = 4'd8;
  localparam logic [HB_W-1:0] MAX_HEADER_BYTES  = 3'd4;
  localparam logic [EB_W-1:0] EB_RESET          = 4'd1;
  localparam logic [HB_W-1:0] HB_RESET          = 3'd1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = {TOTAL_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES  = 8'd1;

  typedef struct packed {
    logic [EB_W-1:0] element_bytes;
    logic [HB_W-1:0] header_bytes;
  } cfg_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  element;
    logic [CNT_W-1:0]   repeat_count;
    logic               is_last;
    logic               truncated;
    logic [TOTAL_W-1:0] total_bytes;
  } result_t;

endpackage

/* rtl/core/rld_decode.sv */
// input register, token state and single-pass decode of one byte
`timescale 1ns / 1ps
module rld_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  rld_pkg::cfg_t         cfg,
  input  logic                  core_ready,
  output logic                  push,
  output rld_pkg::result_t      res
);
  import rld_pkg::*;

  // input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_eos;

  // token state
  logic               in_element_phase;
  logic [POS_W-1:0]   byte_position;
  logic [HDR_W-1:0]   header_accumulator;
  logic [ELEM_W-1:0]  element_accumulator;
  logic               repeat_mode;
  logic [CNT_W-1:0]   literals_remaining;
  logic [TOTAL_W-1:0] byte_total;

  logic               in_element_phase_next;
  logic [POS_W-1:0]   byte_position_next;
  logic [HDR_W-1:0]   header_accumulator_next;
  logic [ELEM_W-1:0]  element_accumulator_next;
  logic               repeat_mode_next;
  logic [CNT_W-1:0]   literals_remaining_next;
  logic [TOTAL_W-1:0] byte_total_next;

  logic                advance;
  logic                has_result;
  logic [EB_W-1:0]     eb;
  logic [HB_W-1:0]     hb;
  logic [POS_W:0]      np;
  logic [HDR_W-1:0]    hacc_new;
  logic [ELEM_W-1:0]   eacc_new;
  logic                hdr_top;
  logic [CNT_W-1:0]    hdr_rest;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    lit_dec;
  logic                token_done;
  logic [PROD_W-1:0]   prod;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  total_new;

  assign advance       = s1_valid & core_ready;
  assign s_axis_tready = ~s1_valid | core_ready;
  assign push          = advance & has_result;

  // effective sizes: zero acts as one, large values clamp
  always_comb begin
    if (cfg.element_bytes == '0) begin
      eb = EB_W'(1);
    end else if (cfg.element_bytes > MAX_ELEMENT_BYTES) begin
      eb = MAX_ELEMENT_BYTES;
    end else begin
      eb = cfg.element_bytes;
    end
    if (cfg.header_bytes == '0) begin
      hb = HB_W'(1);
    end else if (cfg.header_bytes > MAX_HEADER_BYTES) begin
      hb = MAX_HEADER_BYTES;
    end else begin
      hb = cfg.header_bytes;
    end
  end

  // byte merge into accumulators
  assign np       = {1'b0, byte_position} + (POS_W+1)'(1);
  assign hacc_new = header_accumulator |
                    (HDR_W'(s1_byte) << {byte_position[1:0], 3'b000});
  assign eacc_new = element_accumulator |
                    (ELEM_W'(s1_byte) << {byte_position, 3'b000});

  // header split: top bit selects repeat, rest is count minus one
  always_comb begin
    case (hb)
      3'd1: begin
        hdr_top  = hacc_new[7];
        hdr_rest = CNT_W'(hacc_new[6:0]);
      end
      3'd2: begin
        hdr_top  = hacc_new[15];
        hdr_rest = CNT_W'(hacc_new[14:0]);
      end
      3'd3: begin
        hdr_top  = hacc_new[23];
        hdr_rest = CNT_W'(hacc_new[22:0]);
      end
      default: begin
        hdr_top  = hacc_new[31];
        hdr_rest = CNT_W'(hacc_new[30:0]);
      end
    endcase
  end

  // element count and running total
  assign cnt        = repeat_mode ? literals_remaining : CNT_W'(1);
  assign lit_dec    = literals_remaining - CNT_W'(1);
  assign token_done = repeat_mode | (lit_dec == '0);
  assign prod       = PROD_W'(cnt) * PROD_W'(eb);
  assign sum        = {1'b0, byte_total} + (TOTAL_W+1)'(prod);
  assign total_new  = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  // next state and result for the byte in the input register
  always_comb begin
    in_element_phase_next    = in_element_phase;
    byte_position_next       = byte_position;
    header_accumulator_next  = header_accumulator;
    element_accumulator_next = element_accumulator;
    repeat_mode_next         = repeat_mode;
    literals_remaining_next  = literals_remaining;
    byte_total_next          = byte_total;
    has_result               = 1'b0;
    res.element              = '0;
    res.repeat_count         = '0;
    res.is_last              = 1'b1;
    res.truncated            = 1'b1;
    res.total_bytes          = byte_total;

    if (!in_element_phase) begin
      if (np >= (POS_W+1)'(hb)) begin
        repeat_mode_next        = hdr_top;
        literals_remaining_next = hdr_rest + CNT_W'(1);
        header_accumulator_next = '0;
        element_accumulator_next = '0;
        byte_position_next      = '0;
        in_element_phase_next   = 1'b1;
      end else begin
        header_accumulator_next = hacc_new;
        byte_position_next      = np[POS_W-1:0];
      end
      has_result = s1_eos;
    end else if (np < (POS_W+1)'(eb)) begin
      element_accumulator_next = eacc_new;
      byte_position_next       = np[POS_W-1:0];
      has_result               = s1_eos;
    end else if (s1_eos && !token_done) begin
      has_result = 1'b1;
    end else begin
      has_result               = 1'b1;
      res.element              = eacc_new;
      res.repeat_count         = cnt;
      res.is_last              = s1_eos;
      res.truncated            = 1'b0;
      res.total_bytes          = total_new;
      byte_total_next          = total_new;
      element_accumulator_next = '0;
      byte_position_next       = '0;
      if (token_done) begin
        in_element_phase_next   = 1'b0;
        repeat_mode_next        = 1'b0;
        literals_remaining_next = '0;
      end else begin
        literals_remaining_next = lit_dec;
      end
    end

    // any end of stream returns to a fresh stream
    if (s1_eos) begin
      in_element_phase_next    = 1'b0;
      byte_position_next       = '0;
      header_accumulator_next  = '0;
      element_accumulator_next = '0;
      repeat_mode_next         = 1'b0;
      literals_remaining_next  = '0;
      byte_total_next          = '0;
    end
  end

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tready) begin
      s1_byte <= s_axis_tdata;
      s1_eos  <= s_axis_tlast;
    end
  end

  // state update once the byte leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_element_phase    <= 1'b0;
      byte_position       <= '0;
      header_accumulator  <= '0;
      element_accumulator <= '0;
      repeat_mode         <= 1'b0;
      literals_remaining  <= '0;
      byte_total          <= '0;
    end else if (advance) begin
      in_element_phase    <= in_element_phase_next;
      byte_position       <= byte_position_next;
      header_accumulator  <= header_accumulator_next;
      element_accumulator <= element_accumulator_next;
      repeat_mode         <= repeat_mode_next;
      literals_remaining  <= literals_remaining_next;
      byte_total          <= byte_total_next;
    end
  end

endmodule

/* rtl/core/rld_out_skid.sv */
// output register with a skid stage for the result channel
`timescale 1ns / 1ps
module rld_out_skid (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rld_pkg::result_t        res,
  output logic                    core_ready,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output rld_pkg::result_t        out_res
);
  import rld_pkg::*;

  logic    out_valid;
  logic    skid_valid;
  result_t skid_res;

  assign core_ready    = ~skid_valid;
  assign m_axis_tvalid = out_valid;

  // main register refills from the skid stage first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_axis_tready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (out_valid && !m_axis_tready) begin
      if (push) begin
        skid_res <= res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (push) begin
      out_res <= res;
    end
  end

endmodule

/* rtl/core/rle_literal_run_decoder_top.sv */
// top level of the run-length decoder with literal runs
//
// byte stream in on s_axis: one encoded byte per beat, tlast on the final
// byte of a stream. results out on m_axis: one decoded element per beat
// with its repeat count and running byte total; tlast closes the stream,
// tuser flags a stream that ended inside a token (discard that stream).
// the user must write element_bytes and header_bytes over the cfg port only while
// idle; the block itself does not enforce it. cfg_ready is always high.
// throughput: one byte per cycle while m_axis does not stall; all decode work
// is one pass of logic between the input register and the output register.
// a byte that yields a result passes the input register and then the output
// register (by way of the skid stage when m_axis stalls) on its way to m_axis.
// reset clears the token state, byte total and all valid flags, and sets
// both sizes to one byte.
// when m_axis stalls, the skid stage takes one more result, then
// s_axis_tready drops once the input register is also held.
`timescale 1ns / 1ps
module rle_literal_run_decoder_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rld_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rld_pkg::BYTE_W-1:0]      s_axis_tdata,   // in_byte
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rld_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // element, repeat_count, total_bytes
  output logic                            m_axis_tlast,
  output logic [0:0]                      m_axis_tuser    // truncated
);
  import rld_pkg::*;

  cfg_t    cfg;
  logic    core_ready;
  logic    push;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.element_bytes <= EB_RESET;
      cfg.header_bytes  <= HB_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ELEMENT_BYTES: cfg.element_bytes <= cfg_data[EB_W-1:0];
        REG_HEADER_BYTES:  cfg.header_bytes  <= cfg_data[HB_W-1:0];
        default: ;
      endcase
    end
  end

  rld_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .cfg           (cfg),
    .core_ready    (core_ready),
    .push          (push),
    .res           (res)
  );

  rld_out_skid u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .res           (res),
    .core_ready    (core_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .out_res       (out_res)
  );

  // output beat packing
  assign m_axis_tdata = {out_res.total_bytes, out_res.repeat_count, out_res.element};
  assign m_axis_tlast = out_res.is_last;
  assign m_axis_tuser = out_res.truncated;

  // a truncation beat closes the stream and carries no count
  a_trunc_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && out_res.repeat_count == '0)
    else $error("truncation beat malformed");

  // a good element always has a nonzero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> out_res.repeat_count != '0)
    else $error("element beat with zero count");

  // skid stage only fills behind a held output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    !core_ready |-> m_axis_tvalid)
    else $error("skid stage full with empty output");

endmodule
